FILE: hdl/sssp_pkg.sv
// Shared types and constants for the single-source shortest path block.
`default_nettype none
package sssp_pkg;

    localparam int MAX_NODES   = 64;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int CNT_W       = $clog2(MAX_NODES + 1);
    localparam int WEIGHT_BITS = 16;
    localparam int WEIGHT_W    = 16;
    localparam int DIST_W      = 22;
    localparam int CFG_W       = 7;
    localparam int EDGE_W      = WEIGHT_BITS + 1;
    localparam int EDGE_DEPTH  = MAX_NODES * MAX_NODES;
    localparam int EDGE_AW     = $clog2(EDGE_DEPTH);

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [WEIGHT_W-1:0] weight;
    } t_req;

    typedef struct packed {
        logic              reachable;
        logic [DIST_W-1:0] path_length;
        logic [NODE_W-1:0] path_node;
        logic              last;
    } t_res;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_CMP,
        ST_ADD_WR2,
        ST_INIT,
        ST_SCAN,
        ST_RELAX,
        ST_FIN,
        ST_FIN_WAIT,
        ST_WALK,
        ST_WALK_WAIT,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

FILE: hdl/sssp_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/single_source_shortest_path_top.sv
// Top level of the single-source shortest path engine.
`default_nettype none
// Usage:
//   Command channel: drive i_req and raise start; the transaction is taken at
//   a rising edge with start high and busy low. Request types: add an
//   undirected edge (keeps the smaller weight), query source->target, clear.
//   Config: i_cfg_we/i_cfg_data set node_count (nodes picked by the scan);
//   write only while busy is low.
//   Results: o_strobe marks o_res for one cycle; the receiver cannot stall.
//   A query yields the path from source to target, one node per transaction,
//   last set on the final one; an unreachable target gives one transaction
//   with reachable cleared.
// Operation:
//   Add: read-compare-write of both matrix entries.
//   Clear: one edge-matrix entry swept per cycle.
//   Query: per Dijkstra round one pass over node_count distances plus one
//   pass over the 64 neighbors, each pass one memory read per cycle, then
//   a parent walk from the target back to the source and output of the
//   path nodes.
// Reset: synchronous; after reset the edge matrix is swept clear with busy
//   high; node_count returns to 64.
module single_source_shortest_path_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire sssp_pkg::t_req             i_req,
    input  wire logic                       i_cfg_we,
    input  wire logic [sssp_pkg::CFG_W-1:0] i_cfg_data,
    output logic                            o_strobe,
    output sssp_pkg::t_res                  o_res
);
    localparam int NW = sssp_pkg::NODE_W;
    localparam int CW = sssp_pkg::CNT_W;
    localparam int DW = sssp_pkg::DIST_W;
    localparam int WB = sssp_pkg::WEIGHT_BITS;
    localparam int EW = sssp_pkg::EDGE_W;
    localparam int EA = sssp_pkg::EDGE_AW;
    localparam int MN = sssp_pkg::MAX_NODES;

    sssp_pkg::t_state r_state, n_state;

    logic [NW-1:0]   r_a, n_a, r_b, n_b, r_pj, n_pj, r_u, n_u, r_cur, n_cur;
    logic [WB-1:0]   r_w, n_w;
    logic [EA-1:0]   r_clr, n_clr;
    logic [CW-1:0]   r_j, n_j, r_cnt, n_cnt, r_k, n_k;
    logic            r_pv, n_pv, r_found, n_found, r_plast, n_plast;
    logic [DW-1:0]   r_best, n_best, r_len, n_len;
    logic [MN-1:0]   r_done, n_done, r_reach, n_reach;
    logic [sssp_pkg::CFG_W-1:0] r_node_count;
    logic            r_stb, n_stb;
    sssp_pkg::t_res  r_res, n_res;

    // memory ports
    logic          e_we;
    logic [EA-1:0] e_waddr, e_raddr;
    logic [EW-1:0] e_wdata, e_rdata;
    logic          d_we;
    logic [NW-1:0] d_waddr, d_raddr;
    logic [DW-1:0] d_wdata, d_rdata;
    logic          p_we;
    logic [NW-1:0] p_waddr, p_raddr, p_wdata, p_rdata;
    logic          q_we;
    logic [NW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

    // Edge matrix: {valid, weight}, address {row, column}
    sssp_ram #(.WIDTH(EW), .DEPTH(sssp_pkg::EDGE_DEPTH)) u_edge (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata)
    );
    sssp_ram #(.WIDTH(DW), .DEPTH(MN)) u_dist (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_waddr), .i_wdata(d_wdata),
        .i_raddr(d_raddr), .o_rdata(d_rdata)
    );
    sssp_ram #(.WIDTH(NW), .DEPTH(MN)) u_parent (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );
    sssp_ram #(.WIDTH(NW), .DEPTH(MN)) u_route (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    // Scan limit: node_count saturated at MAX_NODES
    logic [CW-1:0] lim;
    assign lim = (CW'(r_node_count) > CW'(MN)) ? CW'(MN) : CW'(r_node_count);

    logic add_upd, scan_end, relax_end, walk_stop, emit_end, scan_take, relax_upd;
    logic [DW:0] cand;

    assign add_upd   = !e_rdata[EW-1] || (r_w < e_rdata[WB-1:0]);
    assign scan_end  = (r_j >= lim) && !r_pv;
    assign relax_end = (r_j == CW'(MN)) && !r_pv;
    assign walk_stop = (r_cur == r_a) || (r_cnt == CW'(MN - 1));
    assign emit_end  = (r_k == r_cnt) && !r_pv;
    // running minimum: strict less, so lowest index wins ties
    assign scan_take = r_pv && !r_done[r_pj] && r_reach[r_pj]
                     && (!r_found || d_rdata < r_best);
    assign cand      = {1'b0, r_best} + (DW+1)'(e_rdata[WB-1:0]);
    assign relax_upd = r_pv && e_rdata[EW-1] && !r_done[r_pj]
                     && (!r_reach[r_pj] || cand < {1'b0, d_rdata});

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sssp_pkg::ST_CLEAR:    if (&r_clr) n_state = sssp_pkg::ST_IDLE;
            sssp_pkg::ST_IDLE: begin
                if (start) begin
                    unique case (i_req.req_type)
                        sssp_pkg::REQ_ADD:   n_state = sssp_pkg::ST_ADD_RD;
                        sssp_pkg::REQ_QUERY: n_state = sssp_pkg::ST_INIT;
                        sssp_pkg::REQ_CLEAR: n_state = sssp_pkg::ST_CLEAR;
                        default:             n_state = sssp_pkg::ST_IDLE;
                    endcase
                end
            end
            sssp_pkg::ST_ADD_RD:   n_state = sssp_pkg::ST_ADD_CMP;
            sssp_pkg::ST_ADD_CMP:
                n_state = add_upd ? sssp_pkg::ST_ADD_WR2 : sssp_pkg::ST_IDLE;
            sssp_pkg::ST_ADD_WR2:  n_state = sssp_pkg::ST_IDLE;
            sssp_pkg::ST_INIT:     n_state = sssp_pkg::ST_SCAN;
            sssp_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = r_found ? sssp_pkg::ST_RELAX : sssp_pkg::ST_FIN;
                end
            end
            sssp_pkg::ST_RELAX:    if (relax_end) n_state = sssp_pkg::ST_SCAN;
            sssp_pkg::ST_FIN:      n_state = sssp_pkg::ST_FIN_WAIT;
            sssp_pkg::ST_FIN_WAIT:
                n_state = r_reach[r_b] ? sssp_pkg::ST_WALK : sssp_pkg::ST_IDLE;
            sssp_pkg::ST_WALK:
                n_state = walk_stop ? sssp_pkg::ST_EMIT : sssp_pkg::ST_WALK_WAIT;
            sssp_pkg::ST_WALK_WAIT: n_state = sssp_pkg::ST_WALK;
            sssp_pkg::ST_EMIT:     if (emit_end) n_state = sssp_pkg::ST_IDLE;
            default:               n_state = sssp_pkg::ST_IDLE;
        endcase
    end

    // Datapath, memory ports and outputs
    always_comb begin
        n_a = r_a; n_b = r_b; n_w = r_w; n_clr = r_clr; n_j = r_j; n_pj = r_pj;
        n_pv = 1'b0; n_found = r_found; n_best = r_best; n_u = r_u;
        n_done = r_done; n_reach = r_reach; n_len = r_len; n_cur = r_cur;
        n_cnt = r_cnt; n_k = r_k; n_plast = r_plast;
        n_stb = 1'b0; n_res = r_res;
        e_we = 1'b0; e_waddr = {r_a, r_b}; e_wdata = {1'b1, r_w};
        e_raddr = {r_a, r_b};
        d_we = 1'b0; d_waddr = r_pj; d_wdata = cand[DW-1:0]; d_raddr = r_j[NW-1:0];
        p_we = 1'b0; p_waddr = r_pj; p_wdata = r_u; p_raddr = r_cur;
        q_we = 1'b0; q_waddr = r_cnt[NW-1:0]; q_wdata = r_cur;
        q_raddr = NW'(r_cnt - r_k - CW'(1));

        unique case (r_state)
            sssp_pkg::ST_CLEAR: begin
                e_we    = 1'b1;
                e_waddr = r_clr;
                e_wdata = '0;
                n_clr   = r_clr + EA'(1);
            end
            sssp_pkg::ST_IDLE: begin
                n_a   = i_req.node_a;
                n_b   = i_req.node_b;
                n_w   = i_req.weight[WB-1:0];
                n_clr = '0;
            end
            sssp_pkg::ST_ADD_RD: ;
            sssp_pkg::ST_ADD_CMP: e_we = add_upd;
            sssp_pkg::ST_ADD_WR2: begin
                e_we    = 1'b1;
                e_waddr = {r_b, r_a};
            end
            sssp_pkg::ST_INIT: begin
                d_we    = 1'b1;
                d_waddr = r_a;
                d_wdata = '0;
                n_reach = '0;
                n_reach[r_a] = 1'b1;
                n_done  = '0;
                n_j     = '0;
                n_found = 1'b0;
            end
            sssp_pkg::ST_SCAN: begin
                if (r_j < lim) begin
                    n_pv = 1'b1;
                    n_pj = r_j[NW-1:0];
                    n_j  = r_j + CW'(1);
                end
                if (scan_take) begin
                    n_found = 1'b1;
                    n_best  = d_rdata;
                    n_u     = r_pj;
                end
                if (scan_end) begin
                    n_j = '0;
                    if (r_found) n_done[r_u] = 1'b1;
                end
            end
            sssp_pkg::ST_RELAX: begin
                e_raddr = {r_u, r_j[NW-1:0]};
                if (r_j < CW'(MN)) begin
                    n_pv = 1'b1;
                    n_pj = r_j[NW-1:0];
                    n_j  = r_j + CW'(1);
                end
                if (relax_upd) begin
                    d_we = 1'b1;
                    p_we = 1'b1;
                    n_reach[r_pj] = 1'b1;
                end
                if (relax_end) begin
                    n_j     = '0;
                    n_found = 1'b0;
                end
            end
            sssp_pkg::ST_FIN: d_raddr = r_b;
            sssp_pkg::ST_FIN_WAIT: begin
                n_len = d_rdata;
                n_cur = r_b;
                n_cnt = '0;
                if (!r_reach[r_b]) begin
                    n_stb = 1'b1;
                    n_res = '{reachable: 1'b0, path_length: '0,
                              path_node: r_b, last: 1'b1};
                end
            end
            sssp_pkg::ST_WALK: begin
                q_we  = 1'b1;
                n_cnt = r_cnt + CW'(1);
                n_k   = '0;
            end
            sssp_pkg::ST_WALK_WAIT: n_cur = p_rdata;
            sssp_pkg::ST_EMIT: begin
                if (r_k < r_cnt) begin
                    n_pv    = 1'b1;
                    n_plast = (r_k + CW'(1)) == r_cnt;
                    n_k     = r_k + CW'(1);
                end
                if (r_pv) begin
                    n_stb = 1'b1;
                    n_res = '{reachable: 1'b1, path_length: r_len,
                              path_node: q_rdata, last: r_plast};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sssp_pkg::ST_CLEAR;
            r_clr        <= '0;
            r_pv         <= 1'b0;
            r_stb        <= 1'b0;
            r_found      <= 1'b0;
            r_done       <= '0;
            r_reach      <= '0;
            r_j          <= '0;
            r_cnt        <= '0;
            r_k          <= '0;
            r_node_count <= sssp_pkg::CFG_W'(MN);
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pv    <= n_pv;
            r_stb   <= n_stb;
            r_found <= n_found;
            r_done  <= n_done;
            r_reach <= n_reach;
            r_j     <= n_j;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            if (i_cfg_we) r_node_count <= i_cfg_data;
        end
        r_a <= n_a; r_b <= n_b; r_w <= n_w; r_pj <= n_pj; r_u <= n_u;
        r_best <= n_best; r_len <= n_len; r_cur <= n_cur; r_plast <= n_plast;
        r_res <= n_res;
    end

    assign busy     = (r_state != sssp_pkg::ST_IDLE);
    assign o_strobe = r_stb;
    assign o_res    = r_res;

    // Results come only from the final-check or output states
    a_stb_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stb |-> ($past(r_state) == sssp_pkg::ST_EMIT
                || $past(r_state) == sssp_pkg::ST_FIN_WAIT))
        else $error("result strobe outside output states");

    // A non-final result is always followed by more work
    a_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stb && !r_res.last) |-> busy)
        else $error("idle after non-final result");

    // Path count never exceeds MAX_NODES
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MN))
        else $error("path count overflow");

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the single-source shortest path engine.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 20_000_000;
    localparam int     DRAIN_CYCLES = 64;
    // Request code with no meaning to the block.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    sssp_pkg::t_req                i_req;
    logic                          i_cfg_we;
    logic [sssp_pkg::CFG_W-1:0]    i_cfg_data;
    logic                          o_strobe;
    sssp_pkg::t_res                o_res;

    single_source_shortest_path_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_res      (o_res)
    );

    // Shadow of the graph and the node_count register.
    bit                            edge_ok [sssp_pkg::MAX_NODES][sssp_pkg::MAX_NODES];
    logic [sssp_pkg::WEIGHT_W-1:0] edge_wt [sssp_pkg::MAX_NODES][sssp_pkg::MAX_NODES];
    int unsigned                   nodes_in_use;

    // Path transactions still owed by the block, oldest first.
    sssp_pkg::t_res path_queue[$];

    int     gap_pct;
    int     fail_count;
    int     items_sent;
    int     queries_sent;
    int     results_seen;
    longint cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, path_queue.size());
            $display("testbench failed");
            $finish;
        end
    end

    // Result checker: every strobed transaction must match the oldest expectation.
    always @(posedge i_clk) begin
        sssp_pkg::t_res want;
        if (i_rst_n && o_strobe) begin
            results_seen <= results_seen + 1;
            if (path_queue.size() == 0) begin
                fail_count = fail_count + 1;
                if (fail_count <= 10)
                    $display("unexpected result: reach=%0b len=%0d node=%0d last=%0b",
                             o_res.reachable, o_res.path_length, o_res.path_node,
                             o_res.last);
            end else begin
                want = path_queue.pop_front();
                if (o_res !== want) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10) begin
                        $display("mismatch: want reach=%0b len=%0d node=%0d last=%0b",
                                 want.reachable, want.path_length, want.path_node,
                                 want.last);
                        $display("          got  reach=%0b len=%0d node=%0d last=%0b",
                                 o_res.reachable, o_res.path_length,
                                 o_res.path_node, o_res.last);
                    end
                end
            end
        end
    end

    // Append one expected transaction at the tail of the queue.
    function automatic void expect_result(input sssp_pkg::t_res r);
        path_queue.insert(path_queue.size(), r);
    endfunction

    // Dense Dijkstra over the shadow graph, then queue the source-to-target path.
    task automatic predict_route(input int src, input int dst);
        longint          path_dist [sssp_pkg::MAX_NODES];
        int              parent [sssp_pkg::MAX_NODES];
        bit              reached [sssp_pkg::MAX_NODES];
        bit              visited [sssp_pkg::MAX_NODES];
        int              route [$];
        int              lim, u, cur;
        bit              found;
        longint          cand;
        sssp_pkg::t_res  r;
        lim = (nodes_in_use > sssp_pkg::MAX_NODES) ? sssp_pkg::MAX_NODES : nodes_in_use;
        foreach (path_dist[j]) begin
            path_dist[j] = 0;
            parent[j] = 0;
            reached[j] = 0;
            visited[j] = 0;
        end
        reached[src] = 1;
        parent[src] = src;
        for (int rnd = 0; rnd < lim; rnd++) begin
            found = 0;
            u = 0;
            for (int j = 0; j < lim; j++)
                if (!visited[j] && reached[j]
                    && (!found || path_dist[j] < path_dist[u])) begin
                    found = 1;
                    u = j;
                end
            if (!found) break;
            visited[u] = 1;
            for (int j = 0; j < sssp_pkg::MAX_NODES; j++)
                if (edge_ok[u][j] && !visited[j]) begin
                    cand = path_dist[u] + edge_wt[u][j];
                    if (!reached[j] || cand < path_dist[j]) begin
                        reached[j] = 1;
                        path_dist[j] = cand;
                        parent[j] = u;
                    end
                end
        end
        if (!reached[dst]) begin
            r = '{reachable: 1'b0, path_length: '0,
                  path_node: dst[sssp_pkg::NODE_W-1:0], last: 1'b1};
            expect_result(r);
            return;
        end
        cur = dst;
        while (route.size() < sssp_pkg::MAX_NODES) begin
            route.push_front(cur);
            if (cur == src) break;
            cur = parent[cur];
        end
        foreach (route[k]) begin
            r.reachable   = 1'b1;
            r.path_length = path_dist[dst][sssp_pkg::DIST_W-1:0];
            r.path_node   = route[k][sssp_pkg::NODE_W-1:0];
            r.last        = (k == route.size() - 1);
            expect_result(r);
        end
    endtask

    task automatic predict_request(input sssp_pkg::t_req r);
        case (r.req_type)
            sssp_pkg::REQ_ADD: begin
                if (!edge_ok[r.node_a][r.node_b]
                    || r.weight < edge_wt[r.node_a][r.node_b]) begin
                    edge_ok[r.node_a][r.node_b] = 1;
                    edge_wt[r.node_a][r.node_b] = r.weight;
                    edge_ok[r.node_b][r.node_a] = 1;
                    edge_wt[r.node_b][r.node_a] = r.weight;
                end
            end
            sssp_pkg::REQ_CLEAR: begin
                foreach (edge_ok[x, y]) begin
                    edge_ok[x][y] = 0;
                    edge_wt[x][y] = '0;
                end
            end
            sssp_pkg::REQ_QUERY: begin
                queries_sent++;
                predict_route(r.node_a, r.node_b);
            end
            default: ;
        endcase
    endtask

    // Present one request; it is taken at the first rising edge with busy low.
    task automatic send_item(input sssp_pkg::t_req r);
        @(negedge i_clk);
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_request(r);
        items_sent++;
        if ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(4)) @(negedge i_clk);
        end
    endtask

    function automatic sssp_pkg::t_req make_req(input int kind, input int a,
                                                input int b, input int w);
        sssp_pkg::t_req r;
        r.req_type = kind[1:0];
        r.node_a   = a[sssp_pkg::NODE_W-1:0];
        r.node_b   = b[sssp_pkg::NODE_W-1:0];
        r.weight   = w[sssp_pkg::WEIGHT_W-1:0];
        return r;
    endfunction

    // Quiesce: no request pending, all results in, block no longer busy.
    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (path_queue.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    task automatic write_node_count(input int v);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v[sssp_pkg::CFG_W-1:0];
        nodes_in_use = v & 'h7F;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Extremes, every request type and the corner cases of the search.
    task automatic test_directed();
        write_node_count(64);
        send_item(make_req(sssp_pkg::REQ_QUERY, 5, 5, 0));      // source is target
        send_item(make_req(sssp_pkg::REQ_QUERY, 0, 63, 0));     // empty graph
        send_item(make_req(sssp_pkg::REQ_ADD, 0, 1, 0));        // zero weight
        send_item(make_req(sssp_pkg::REQ_ADD, 1, 63, 65535));   // max weight, top node
        send_item(make_req(sssp_pkg::REQ_ADD, 0, 63, 65535));
        send_item(make_req(sssp_pkg::REQ_ADD, 63, 0, 40000));   // lighter parallel edge wins
        send_item(make_req(sssp_pkg::REQ_ADD, 0, 63, 50000));   // heavier parallel edge dropped
        send_item(make_req(sssp_pkg::REQ_ADD, 2, 2, 1));        // self loop
        send_item(make_req(REQ_UNUSED, 0, 2, 1));               // unknown type, ignored
        send_item(make_req(sssp_pkg::REQ_QUERY, 63, 1, 0));
        send_item(make_req(sssp_pkg::REQ_QUERY, 1, 63, 0));
        send_item(make_req(sssp_pkg::REQ_QUERY, 2, 0, 0));      // isolated source
        send_item(make_req(sssp_pkg::REQ_ADD, 1, 2, 7));
        send_item(make_req(sssp_pkg::REQ_ADD, 0, 2, 7));        // tie on node 2
        send_item(make_req(sssp_pkg::REQ_QUERY, 0, 2, 65535));
        // Nodes at or above node_count are never picked but can be reached.
        write_node_count(2);
        send_item(make_req(sssp_pkg::REQ_QUERY, 0, 63, 0));
        send_item(make_req(sssp_pkg::REQ_QUERY, 2, 1, 0));      // unpicked source
        send_item(make_req(sssp_pkg::REQ_QUERY, 63, 63, 0));
        send_item(make_req(sssp_pkg::REQ_CLEAR, 0, 0, 0));
        send_item(make_req(sssp_pkg::REQ_QUERY, 0, 1, 0));
        wait_idle();
    endtask

    // Random traffic over nodes below span, with some adds over any node; mostly adds and queries.
    task automatic test_random(input int nc, input int span, input int count);
        int             p;
        sssp_pkg::t_req r;
        write_node_count(nc);
        // Rebuild from empty so the phase's graph stays dense.
        send_item(make_req(sssp_pkg::REQ_CLEAR, 0, 0, 0));
        for (int i = 0; i < count; i++) begin
            p = $urandom_range(99);
            r = make_req(sssp_pkg::REQ_ADD, $urandom_range(span - 1),
                         $urandom_range(span - 1),
                         ($urandom_range(3) == 0) ? $urandom : $urandom_range(40));
            if (p < 35) r.req_type = sssp_pkg::REQ_QUERY;
            else if (p < 37) r.req_type = sssp_pkg::REQ_CLEAR;
            else if (p < 40) r.req_type = REQ_UNUSED;
            else if (p < 44) begin
                r.node_a = sssp_pkg::NODE_W'($urandom);
                r.node_b = sssp_pkg::NODE_W'($urandom);
            end
            send_item(r);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        gap_pct     = 35;
        fail_count  = 0;
        items_sent  = 0;
        queries_sent = 0;
        results_seen = 0;
        cycle_count = 0;
        nodes_in_use = 64;
        foreach (edge_ok[x, y]) begin
            edge_ok[x][y] = 0;
            edge_wt[x][y] = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(16, 16, 60);
        test_random(6, 8, 40);
        gap_pct = 73;
        test_random(127, 64, 30);
        test_random(1, 4, 20);
        gap_pct = 0;
        test_random(0, 4, 15);
        test_random(40, 48, 50);
        test_random(64, 20, 60);

        wait_idle();
        if (path_queue.size() != 0) fail_count++;
        $display("sent %0d transactions (%0d queries), checked %0d path results",
                 items_sent, queries_sent, results_seen);
        $display("node_count swept 0..127 with mixed sender gaps, %0d mismatches",
                 fail_count);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
`default_nettype wire
